@@ rtl/pwl_pkg.sv @@
package pwl_pkg;

    // Field widths
    localparam int POS_W       = 17;   // sample_position, Q0.16 with room for 1.0 and above
    localparam int X_W         = 32;   // breakpoint x, unsigned Q16.16
    localparam int Y_W         = 32;   // breakpoint y and curve value, signed Q16.16
    localparam int POINT_W     = X_W + Y_W;
    localparam int COUNT_W     = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = POINT_W;

    // |dy| < 2^Y_W and dt < 2^POS_W
    localparam int MAG_W  = Y_W;
    localparam int PROD_W = MAG_W + POS_W;

    localparam int MAX_POINTS_DEF = 7;

    // Register map
    localparam logic [CFG_INDEX_W-1:0] REG_POINT_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POINT_BASE  = 3'd1;

    typedef logic [POS_W-1:0]          pos_t;
    typedef logic [X_W-1:0]            xval_t;
    typedef logic signed [Y_W-1:0]     yval_t;
    typedef logic [COUNT_W-1:0]        count_t;
    typedef logic [CFG_INDEX_W-1:0]    cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]     cfg_data_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [PROD_W-1:0]         prod_t;

    // x sits in the upper half of the register, y in the lower half
    typedef struct packed {
        xval_t x;
        yval_t y;
    } point_t;

    // Per-item control that rides alongside the arithmetic
    typedef struct packed {
        logic  found;
        logic  zero_dx;   // value is y0 as is
        logic  neg;       // dy is negative
        yval_t y0;
    } side_t;

endpackage

@@ rtl/pwl_in_if.sv @@
interface pwl_in_if;
    import pwl_pkg::*;

    logic valid;
    logic ready;
    pos_t sample_position;

    modport source (output valid, output sample_position, input ready);
    modport sink   (input valid, input sample_position, output ready);
endinterface

@@ rtl/pwl_out_if.sv @@
interface pwl_out_if;
    import pwl_pkg::*;

    logic  valid;
    logic  ready;
    yval_t curve_value;
    logic  segment_found;

    modport source (output valid, output curve_value, output segment_found, input ready);
    modport sink   (input valid, input curve_value, input segment_found, output ready);
endinterface

@@ rtl/pwl_seg_select.sv @@
module pwl_seg_select #(
    parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_valid,
    input  pwl_pkg::pos_t    t,
    input  pwl_pkg::count_t  point_count,
    input  pwl_pkg::point_t  points [MAX_POINTS],
    output logic             out_valid,
    output pwl_pkg::side_t   out_side,
    output pwl_pkg::xval_t   out_dx,
    output pwl_pkg::pos_t    out_dt,
    output pwl_pkg::mag_t    out_mag
);
    import pwl_pkg::*;

    localparam int SEGS = MAX_POINTS - 1;

    count_t          n_eff;
    logic [SEGS-1:0] hit;
    logic            pick_found;
    logic            pick_single;
    point_t          pick_p0;
    point_t          pick_p1;

    // Stage A: segment search
    logic   a_valid_reg;
    logic   a_found_reg;
    logic   a_single_reg;
    point_t a_p0_reg;
    point_t a_p1_reg;
    pos_t   a_t_reg;

    // Stage B: differences
    logic              b_valid_reg;
    side_t             b_side_reg;
    xval_t             b_dx_reg;
    pos_t              b_dt_reg;
    mag_t              b_mag_reg;
    xval_t             dx_next;
    logic signed [Y_W:0] dy_next;

    always_comb
    begin
        n_eff = (point_count > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : point_count;
        for (int i = 0; i < SEGS; i++)
        begin
            hit[i] = (n_eff > COUNT_W'(i + 1))
                   && ({15'd0, t} >= points[i].x)
                   && ({15'd0, t} <= points[i + 1].x);
        end
        pick_single = (n_eff == COUNT_W'(1));
        pick_found  = pick_single || (|hit);
        pick_p0     = points[0];
        pick_p1     = points[1];
        // Lowest matching segment wins: walk from the top down
        for (int i = SEGS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                pick_p0 = points[i];
                pick_p1 = points[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_found_reg  <= pick_found;
            a_single_reg <= pick_single;
            a_p0_reg     <= pick_p0;
            a_p1_reg     <= pick_p1;
            a_t_reg      <= t;
        end
    end

    always_comb
    begin
        dx_next = a_p1_reg.x - a_p0_reg.x;
        dy_next = {a_p1_reg.y[Y_W-1], a_p1_reg.y} - {a_p0_reg.y[Y_W-1], a_p0_reg.y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_side_reg.found   <= a_found_reg;
            b_side_reg.zero_dx <= a_single_reg || (dx_next == '0);
            b_side_reg.neg     <= dy_next[Y_W];
            b_side_reg.y0      <= a_p0_reg.y;
            b_dx_reg           <= dx_next;
            // t >= x0 on a hit, so the low bits carry the whole offset
            b_dt_reg           <= a_t_reg - a_p0_reg.x[POS_W-1:0];
            b_mag_reg          <= dy_next[Y_W] ? MAG_W'(-dy_next) : MAG_W'(dy_next);
        end
    end

    assign out_valid = b_valid_reg;
    assign out_side  = b_side_reg;
    assign out_dx    = b_dx_reg;
    assign out_dt    = b_dt_reg;
    assign out_mag   = b_mag_reg;

endmodule

@@ rtl/pwl_mul.sv @@
module pwl_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            in_valid,
    input  pwl_pkg::side_t  in_side,
    input  pwl_pkg::xval_t  in_dx,
    input  pwl_pkg::pos_t   in_dt,
    input  pwl_pkg::mag_t   in_mag,
    output logic            out_valid,
    output pwl_pkg::side_t  out_side,
    output pwl_pkg::xval_t  out_dx,
    output pwl_pkg::prod_t  out_prod
);
    import pwl_pkg::*;

    logic  valid_reg;
    side_t side_reg;
    xval_t dx_reg;
    prod_t prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // |dy| * dt, a 32 x 17 product
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg <= in_side;
            dx_reg   <= in_dx;
            prod_reg <= PROD_W'(in_mag) * PROD_W'(in_dt);
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_dx    = dx_reg;
    assign out_prod  = prod_reg;

endmodule

@@ rtl/pwl_div.sv @@
module pwl_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            in_valid,
    input  pwl_pkg::side_t  in_side,
    input  pwl_pkg::xval_t  in_dx,
    input  pwl_pkg::prod_t  in_prod,
    output logic            out_valid,
    output pwl_pkg::side_t  out_side,
    output pwl_pkg::mag_t   out_quot
);
    import pwl_pkg::*;

    // One quotient bit per stage; the quotient never exceeds |dy|
    localparam int STAGES = MAG_W;
    localparam int HEAD_W = PROD_W - MAG_W;

    logic  valid_reg [STAGES];
    side_t side_reg  [STAGES];
    xval_t dx_reg    [STAGES];
    xval_t rem_reg   [STAGES];
    mag_t  lo_reg    [STAGES];   // dividend bits still to come on top, quotient bits below

    xval_t rem_next  [STAGES];
    mag_t  lo_next   [STAGES];

    always_comb
    begin
        logic [X_W+1:0] diff;
        logic [X_W:0]   shifted;
        xval_t          rem_in;
        mag_t           lo_in;
        xval_t          dx_in;
        for (int k = 0; k < STAGES; k++)
        begin
            if (k == 0)
            begin
                // Dividend >> MAG_W is below dx, so it seeds the remainder
                rem_in = X_W'(in_prod[PROD_W-1:MAG_W]);
                lo_in  = in_prod[MAG_W-1:0];
                dx_in  = in_dx;
            end
            else
            begin
                rem_in = rem_reg[k - 1];
                lo_in  = lo_reg[k - 1];
                dx_in  = dx_reg[k - 1];
            end
            shifted = {rem_in, lo_in[MAG_W-1]};
            diff    = {1'b0, shifted} - {2'b00, dx_in};
            if (!diff[X_W+1])
            begin
                rem_next[k] = diff[X_W-1:0];
                lo_next[k]  = {lo_in[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = shifted[X_W-1:0];
                lo_next[k]  = {lo_in[MAG_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < STAGES; k++)
            begin
                valid_reg[k] <= valid_reg[k - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= in_side;
            dx_reg[0]   <= in_dx;
            for (int k = 1; k < STAGES; k++)
            begin
                side_reg[k] <= side_reg[k - 1];
                dx_reg[k]   <= dx_reg[k - 1];
            end
            for (int k = 0; k < STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                lo_reg[k]  <= lo_next[k];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
    assign out_quot  = lo_reg[STAGES-1];

    // The head width check keeps the seed no wider than the divisor
    if (HEAD_W > X_W)
    begin : g_bad_width
        $error("pwl_div: dividend head wider than divisor");
    end

endmodule

@@ rtl/piecewise_linear_curve_eval.sv @@
// Piecewise linear curve evaluator.
//
// Channels: "sample" takes one position t (Q0.16, 17 bits) per item; "result"
// returns one item per sample: curve_value (signed Q16.16) and segment_found.
// Both use valid/ready; an item moves on a clock edge with valid and ready high.
// Breakpoints and point_count are loaded through the cfg_we/cfg_index/cfg_data
// write port; the user loads them only while no item is in flight (not enforced).
//
// Path: an accepted sample goes through search, difference, multiply, 32 divider
// steps and the output register before its result shows on the result channel.
// Throughput: one item per cycle while the result is not stalled. The restoring
// divider retires one quotient bit per stage, 32 stages deep, and sets the latency;
// every stage is free for a new item each cycle unless the pipeline is stalled.
//
// Reset: all valid bits clear, point_count and every breakpoint read as zero.
// Stall: when the result is held and not taken, the whole pipeline freezes in
// place and sample.ready drops in the same cycle; nothing is lost or repeated.
module piecewise_linear_curve_eval #(
    parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    pwl_in_if.sink               sample,
    pwl_out_if.source            result,
    input  logic                 cfg_we,
    input  pwl_pkg::cfg_index_t  cfg_index,
    input  pwl_pkg::cfg_data_t   cfg_data
);
    import pwl_pkg::*;

    // Configuration registers
    count_t point_count_reg;
    point_t point_reg [MAX_POINTS];

    // Pipeline wiring
    logic  advance;
    logic  sel_valid;
    side_t sel_side;
    xval_t sel_dx;
    pos_t  sel_dt;
    mag_t  sel_mag;
    logic  mul_valid;
    side_t mul_side;
    xval_t mul_dx;
    prod_t mul_prod;
    logic  div_valid;
    side_t div_side;
    mag_t  div_quot;

    // Output register
    logic  out_valid_reg;
    yval_t out_value_reg;
    logic  out_found_reg;
    yval_t value_next;

    // Advance everything when the output slot is empty or being emptied
    assign advance      = !out_valid_reg || result.ready;
    assign sample.ready = advance;

    // Write configuration; indexes past the last breakpoint are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                point_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_POINT_COUNT)
            begin
                point_count_reg <= cfg_data[COUNT_W-1:0];
            end
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                if (cfg_index == REG_POINT_BASE + CFG_INDEX_W'(i))
                begin
                    point_reg[i] <= point_t'(cfg_data);
                end
            end
        end
    end

    // Find the segment and form dx, dt, |dy|
    pwl_seg_select #(
        .MAX_POINTS (MAX_POINTS)
    ) u_seg_select (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (sample.valid),
        .t           (sample.sample_position),
        .point_count (point_count_reg),
        .points      (point_reg),
        .out_valid   (sel_valid),
        .out_side    (sel_side),
        .out_dx      (sel_dx),
        .out_dt      (sel_dt),
        .out_mag     (sel_mag)
    );

    // |dy| * dt
    pwl_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (sel_valid),
        .in_side   (sel_side),
        .in_dx     (sel_dx),
        .in_dt     (sel_dt),
        .in_mag    (sel_mag),
        .out_valid (mul_valid),
        .out_side  (mul_side),
        .out_dx    (mul_dx),
        .out_prod  (mul_prod)
    );

    // Divide by dx, truncating; a magnitude quotient gives truncation toward zero
    pwl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (mul_valid),
        .in_side   (mul_side),
        .in_dx     (mul_dx),
        .in_prod   (mul_prod),
        .out_valid (div_valid),
        .out_side  (div_side),
        .out_quot  (div_quot)
    );

    // Apply sign to the step; a miss gives zero, a zero-width segment or a lone point y0.
    // The result lies between y0 and y1, so 32-bit wraparound never bites.
    always_comb
    begin
        if (!div_side.found)
        begin
            value_next = '0;
        end
        else if (div_side.zero_dx)
        begin
            value_next = div_side.y0;
        end
        else if (div_side.neg)
        begin
            value_next = div_side.y0 - yval_t'(div_quot);
        end
        else
        begin
            value_next = div_side.y0 + yval_t'(div_quot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_value_reg <= value_next;
            out_found_reg <= div_side.found;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.curve_value   = out_value_reg;
    assign result.segment_found = out_found_reg;

endmodule

@@ rtl/pwl_checker.sv @@
module pwl_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_ready,
    input  logic           out_valid,
    input  logic           out_ready,
    input  pwl_pkg::yval_t curve_value,
    input  logic           segment_found
);
    import pwl_pkg::*;

    // A held result keeps its payload until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(curve_value) && $stable(segment_found))
        else $error("result changed while stalled");

    // A miss always reports the default zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !segment_found |-> curve_value == '0)
        else $error("miss with nonzero value");

    // Input back-pressure only comes from a stalled result
    a_ready_src: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("sample stalled without result stall");

    // An offered item goes straight in while the result slot is free
    a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !out_valid |-> in_ready)
        else $error("sample refused with free result slot");

    // Nothing pending right out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid at reset release");

endmodule

bind piecewise_linear_curve_eval pwl_checker u_pwl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample.valid),
    .in_ready      (sample.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .curve_value   (result.curve_value),
    .segment_found (result.segment_found)
);

@@ bench/pwl_curve_checker.sv @@
module pwl_curve_checker (
    input  logic                clk,
    input  logic                rst_n,
    pwl_in_if                   sample,
    pwl_out_if                  result,
    input  logic                cfg_we,
    input  pwl_pkg::cfg_index_t cfg_index,
    input  pwl_pkg::cfg_data_t  cfg_data,
    output int                  outstanding,
    output int                  errors
);
    import pwl_pkg::*;

    typedef struct packed {
        pos_t  pos;
        yval_t value;
        logic  found;
    } curve_result_t;

    count_t        n_points;
    point_t        curve_pts [MAX_POINTS_DEF];
    curve_result_t curve_q [$];
    int            fail_tally;

    // Value of the stored curve at position t; first matching segment wins.
    function automatic curve_result_t eval_curve(pos_t t);
        curve_result_t r;
        int unsigned   n;
        int unsigned   i;
        xval_t         x0;
        xval_t         x1;
        longint        y0;
        longint        dy;
        longint        sum;
        longint unsigned dx;
        longint unsigned dt;
        longint unsigned mag;
        longint unsigned q;
        r.pos   = t;
        r.value = '0;
        r.found = 1'b0;
        n = n_points;
        if (n > MAX_POINTS_DEF)
            n = MAX_POINTS_DEF;
        if (n == 1)
        begin
            r.value = curve_pts[0].y;
            r.found = 1'b1;
        end
        else
        begin
            for (i = 0; i + 1 < n && !r.found; i++)
            begin
                x0 = curve_pts[i].x;
                x1 = curve_pts[i + 1].x;
                if (t >= x0 && t <= x1)
                begin
                    y0  = $signed(curve_pts[i].y);
                    dy  = $signed(curve_pts[i + 1].y) - y0;
                    dx  = x1 - x0;
                    dt  = t - x0;
                    r.found = 1'b1;
                    if (dx == 0)
                        r.value = curve_pts[i].y;
                    else
                    begin
                        mag = (dy < 0) ? -dy : dy;
                        q   = (mag * dt) / dx;
                        sum = (dy < 0) ? y0 - longint'(q) : y0 + longint'(q);
                        r.value = sum[Y_W-1:0];
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        curve_result_t want;
        int i;
        if (!rst_n)
        begin
            n_points = '0;
            for (i = 0; i < MAX_POINTS_DEF; i++)
                curve_pts[i] = '0;
            curve_q.delete();
            fail_tally = 0;
            outstanding <= 0;
            errors      <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (curve_q.size() == 0)
                begin
                    if (fail_tally < 10)
                        $display("curve_check: unexpected item value=%0d found=%0b",
                                 result.curve_value, result.segment_found);
                    fail_tally++;
                end
                else
                begin
                    want = curve_q.pop_front();
                    if (result.curve_value !== want.value ||
                        result.segment_found !== want.found)
                    begin
                        if (fail_tally < 10)
                            $display({"curve_check: t=%0d expected value=%0d found=%0b,",
                                      " got value=%0d found=%0b"},
                                     want.pos, want.value, want.found,
                                     result.curve_value, result.segment_found);
                        fail_tally++;
                    end
                end
            end
            if (sample.valid && sample.ready)
                curve_q.insert(curve_q.size(), eval_curve(sample.sample_position));
            // apply a write after predicting, so a same-edge item sees the old curve
            if (cfg_we)
            begin
                if (cfg_index == REG_POINT_COUNT)
                    n_points = cfg_data[COUNT_W-1:0];
                else
                    curve_pts[cfg_index - REG_POINT_BASE] = cfg_data;
            end
            outstanding <= curve_q.size();
            errors      <= fail_tally;
        end
    end

endmodule

@@ bench/tb.sv @@
module tb;
    import pwl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;     // longer than the pipeline from sample to result

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;

    pwl_in_if  sample_ch ();
    pwl_out_if result_ch ();

    int   outstanding;
    int   error_count;
    int   cycle_count;
    logic calm;              // high: neither side idles

    // Breakpoints staged here before they go out on the write port
    point_t curve [MAX_POINTS_DEF];

    piecewise_linear_curve_eval dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pwl_curve_checker curve_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample_ch),
        .result      (result_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .errors      (error_count)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stall the result side about a third of the time, except in the calm stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= calm || ($urandom_range(0, 99) >= 35);
    end

    // Bail out if the run hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one position and hold it until the block takes it; idle first at random.
    task automatic send_position(pos_t t);
        while (!calm && $urandom_range(0, 99) < 35)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid           <= 1'b1;
        sample_ch.sample_position <= t;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every expected item has come back.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Write the count, then all seven breakpoints, back to back; only call when idle.
    // Junk above the count bits checks that only the low bits are kept.
    task automatic load_curve(count_t n);
        cfg_data_t junk;
        int i;
        junk = {$urandom, $urandom};
        junk[COUNT_W-1:0] = n;
        cfg_we    <= 1'b1;
        cfg_index <= REG_POINT_COUNT;
        cfg_data  <= junk;
        @(posedge clk);
        for (i = 0; i < MAX_POINTS_DEF; i++)
        begin
            cfg_index <= REG_POINT_BASE + cfg_index_t'(i);
            cfg_data  <= curve[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Random curve: mostly rising x with the odd zero-width segment,
    // some shuffled x, and a few with x anywhere in 32 bits.
    task automatic build_curve(output count_t n);
        int          r;
        int          style;
        int          i;
        logic [31:0] x;
        r = $urandom_range(0, 99);
        if (r < 10)
            n = '0;
        else if (r < 20)
            n = count_t'(1);
        else
            n = count_t'($urandom_range(2, MAX_POINTS_DEF));
        style = $urandom_range(0, 99);
        x = $urandom_range(0, 8192);
        for (i = 0; i < MAX_POINTS_DEF; i++)
        begin
            if (style < 75)
            begin
                // one step in ten repeats x to make a zero-width segment
                if (i > 0 && $urandom_range(0, 9) != 0)
                    x = x + $urandom_range(1, 16384);
                if (x > 65536)
                    x = 65536;
            end
            else if (style < 90)
                x = $urandom_range(0, 65536);
            else
                x = $urandom;
            curve[i].x = x;
            r = $urandom_range(0, 99);
            if (r < 70)
                curve[i].y = $urandom;
            else if (r < 85)
                curve[i].y = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            else
                curve[i].y = $urandom_range(0, 131072) - 65536;
        end
    endtask

    // Random position: the unit range, on or next to a breakpoint, any 17-bit value, or an extreme.
    function automatic pos_t pick_position();
        int          r;
        int unsigned k;
        r = $urandom_range(0, 99);
        if (r < 45)
            return pos_t'($urandom_range(0, 65536));
        if (r < 75)
        begin
            k = $urandom_range(0, MAX_POINTS_DEF - 1);
            return pos_t'(curve[k].x + $urandom_range(0, 2) - 1);
        end
        if (r < 90)
            return pos_t'($urandom_range(0, 131071));
        case ($urandom_range(0, 3))
            0:       return pos_t'(0);
            1:       return pos_t'(1);
            2:       return pos_t'(65536);
            default: return pos_t'(131071);
        endcase
    endfunction

    initial
    begin
        pos_t   probes [$];
        count_t n;
        int     ph;
        int     k;
        int     items;

        // Hold every input at a known value while reset is held.
        rst_n                     <= 1'b0;
        cfg_we                    <= 1'b0;
        cfg_index                 <= REG_POINT_COUNT;
        cfg_data                  <= '0;
        sample_ch.valid           <= 1'b0;
        sample_ch.sample_position <= '0;
        calm                      <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No breakpoints straight out of reset: value zero, flag low.
        probes = {pos_t'(0), pos_t'(65536)};
        foreach (probes[j])
            send_position(probes[j]);

        // One breakpoint: its y at any position, even above one.
        settle();
        curve[0] = {32'h0000_8000, 32'h7FFF_FFFF};
        load_curve(count_t'(1));
        probes = {pos_t'(0), pos_t'(131071)};
        foreach (probes[j])
            send_position(probes[j]);

        // Full seven points: zero-width first segment, y swinging between the
        // extremes (widest dy), t below, between and past the breakpoints, and on some of them.
        settle();
        curve[0] = {32'h0000_1000, 32'h8000_0000};
        curve[1] = {32'h0000_1000, 32'h7FFF_FFFF};
        curve[2] = {32'h0000_3000, 32'h7FFF_FFFF};
        curve[3] = {32'h0000_5000, 32'h8000_0000};
        curve[4] = {32'h0000_8000, 32'h0000_0000};
        curve[5] = {32'h0000_C000, 32'hFFFF_CFC7};
        curve[6] = {32'h0001_0000, 32'h0001_0000};
        load_curve(count_t'(7));
        probes = {pos_t'(0), pos_t'('h1000), pos_t'('h1001), pos_t'('h2000),
                  pos_t'('h3000), pos_t'('h4000), pos_t'('h4FFF), pos_t'('h5000),
                  pos_t'('h6ABC), pos_t'('hA000), pos_t'('hFFFF), pos_t'('h10000),
                  pos_t'('h10001), pos_t'('h1FFFF)};
        foreach (probes[j])
            send_position(probes[j]);

        // Breakpoints out of order, last x at the top of 32 bits: a gap with no
        // match, then a very wide segment that reaches past one.
        settle();
        curve[0] = {32'h0000_8000, 32'd100};
        curve[1] = {32'h0000_4000, 32'd200};
        curve[2] = {32'hFFFF_FFFF, 32'd5};
        load_curve(count_t'(3));
        probes = {pos_t'('h2000), pos_t'('h6000), pos_t'('h1FFFF)};
        foreach (probes[j])
            send_position(probes[j]);

        // Random curves, each followed by a burst of positions; phases 10..12 run
        // with no idling on either side.
        for (ph = 0; ph < 24; ph++)
        begin
            settle();
            calm <= (ph >= 10 && ph < 13);
            build_curve(n);
            load_curve(n);
            items = $urandom_range(50, 90);
            for (k = 0; k < items; k++)
                send_position(pick_position());
        end

        // Drain, give the pipeline time to show any stray item, then report.
        settle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
